FILE: hw/rtl/sm3_pkg.sv
// ----------------------------------------------------------------------------
// SM3 package
// Shared types, constants and round functions for the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

  localparam logic [1:0] OP_ABSORB  = 2'd0;
  localparam logic [1:0] OP_FINISH  = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [31:0] T_LOW  = 32'h79CC4519;
  localparam logic [31:0] T_HIGH = 32'h7A879D8A;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
  } cmd_t;

  function automatic word_t iv_word(input logic [2:0] idx);
    word_t r;
    unique case (idx)
      3'd0: r = 32'h7380166F;
      3'd1: r = 32'h4914B2B9;
      3'd2: r = 32'h172442D7;
      3'd3: r = 32'hDA8A0600;
      3'd4: r = 32'hA96F30BC;
      3'd5: r = 32'h163138AA;
      3'd6: r = 32'hE38DEE4D;
      default: r = 32'hB0FB0E4E;
    endcase
    return r;
  endfunction

  function automatic word_t rotl(input word_t x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic word_t perm0(input word_t x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic word_t perm1(input word_t x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

FILE: hw/rtl/sm3_hash_engine_top.sv
// ----------------------------------------------------------------------------
// SM3 hash engine top level
// Byte-stream SM3 hasher with a command queue in front of the compressor.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, in_opcode, in_data_byte): each
//   transaction is one command. Absorb adds a byte, finish pads and returns
//   the digest, restart loads the initial vector. Opcode 3 is dropped.
//   Result channel (out_valid/out_ready): finish returns eight transactions,
//   words 0..7, last on word 7; absorb after finish returns one error
//   transaction (status 1). A repeated finish returns the same digest.
//   Throughput: the queue registers each command; the back end takes each
//   byte without waiting, except that every 64th byte starts a load of the
//   sixteen block words and 64 rounds (one round per cycle in a single round
//   unit). Finish costs up to two padded blocks plus eight output words.
//   The two-entry queue lets the sender keep issuing while the back end
//   compresses.
//   Reset: synchronous, active low; the chaining value takes the initial
//   vector and the queue empties.
//   Stall: a stalled receiver holds the current word; the back end waits and
//   the queue fills, then in_ready drops.
// ----------------------------------------------------------------------------
module sm3_hash_engine_top #(
  parameter int unsigned QUEUE_DEPTH = sm3_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last,
  output logic        out_status
);
  sm3_pkg::cmd_t in_cmd, q_cmd;
  logic          q_valid, q_ready;

  // pack the incoming transaction for the queue
  assign in_cmd.opcode    = in_opcode;
  assign in_cmd.data_byte = in_data_byte;

  sm3_cmd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n,
    .wr_valid(in_valid), .wr_ready(in_ready), .wr_data(in_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
  );

  sm3_core u_core (
    .clk, .rst_n,
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .out_valid, .out_ready, .out_digest_word, .out_word_index,
    .out_last, .out_status
  );
endmodule

FILE: hw/rtl/sm3_cmd_queue.sv
// ----------------------------------------------------------------------------
// SM3 command queue
// Short FIFO between the front end and the compression back end.
// ----------------------------------------------------------------------------
module sm3_cmd_queue #(
  parameter int unsigned DEPTH = sm3_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  sm3_pkg::cmd_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output sm3_pkg::cmd_t rd_data
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sm3_pkg::cmd_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          wr_en, rd_en;

  assign wr_ready = (cnt_r != (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (rd_en) begin
        rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end
endmodule

FILE: hw/rtl/sm3_core.sv
// ----------------------------------------------------------------------------
// SM3 back end
// Buffers message bytes, pads, runs one compression round per cycle and
// streams digest words.
// ----------------------------------------------------------------------------
module sm3_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  sm3_pkg::cmd_t cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   out_digest_word,
  output logic [2:0]    out_word_index,
  output logic          out_last,
  output logic          out_status
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_ERR  = 3'd5;

  logic [2:0]  st_r;
  sm3_pkg::word_t buf_r [16];  // message block, big-endian words
  logic [5:0]  pos_r;
  logic [63:0] bits_r;
  logic        fin_r;
  logic        padding_r;   // compression belongs to finish
  logic        second_r;    // a length-only block still follows
  logic [5:0]  pidx_r;      // padding fill index
  logic        pad_lenblk_r;
  sm3_pkg::word_t v_r [8];
  sm3_pkg::word_t w_r [16];  // sliding window W[j..j+15]
  sm3_pkg::word_t a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [5:0]  j_r;
  logic [3:0]  ld_r;
  logic [2:0]  k_r;

  // buffer read for word loading
  sm3_pkg::word_t ld_word;
  always_comb begin
    ld_word = buf_r[ld_r];
  end

  // round datapath
  sm3_pkg::word_t w16, wp, tj, ff, gg, a12, ss1, ss2, tt1, tt2;
  always_comb begin
    w16 = sm3_pkg::perm1(w_r[0] ^ w_r[7] ^ sm3_pkg::rotl(w_r[13], 5'd15))
          ^ sm3_pkg::rotl(w_r[3], 5'd7) ^ w_r[10];
    wp  = w_r[0] ^ w_r[4];
    if (j_r < 6'd16) begin
      tj = sm3_pkg::T_LOW;
      ff = a_r ^ b_r ^ c_r;
      gg = e_r ^ f_r ^ g_r;
    end else begin
      tj = sm3_pkg::T_HIGH;
      ff = (a_r & b_r) | (b_r & c_r) | (a_r & c_r);
      gg = (e_r & f_r) | (~e_r & g_r);
    end
    a12 = sm3_pkg::rotl(a_r, 5'd12);
    ss1 = sm3_pkg::rotl(a12 + e_r + sm3_pkg::rotl(tj, j_r[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    tt1 = ff + d_r + ss2 + wp;
    tt2 = gg + h_r + ss1 + w_r[0];
  end

  assign cmd_ready       = (st_r == S_IDLE);
  assign out_valid       = (st_r == S_EMIT) || (st_r == S_ERR);
  assign out_digest_word = (st_r == S_ERR) ? 32'd0 : v_r[k_r];
  assign out_word_index  = (st_r == S_ERR) ? 3'd0 : k_r;
  assign out_last        = (st_r == S_ERR) || (k_r == 3'd7);
  assign out_status      = (st_r == S_ERR);

  // padding byte at pidx_r
  logic [7:0] pad_byte;
  always_comb begin
    if (pidx_r >= 6'd56 && pad_lenblk_r) begin
      pad_byte = bits_r[8*(7-pidx_r[2:0]) +: 8];
    end else begin
      pad_byte = 8'd0;
    end
  end

  // byte lane 0 of a word is its most significant byte
  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && cmd_valid && cmd.opcode == sm3_pkg::OP_ABSORB && !fin_r) begin
      buf_r[pos_r[5:2]][{~pos_r[1:0], 3'd0} +: 8] <= cmd.data_byte;
    end else if (st_r == S_IDLE && cmd_valid && cmd.opcode == sm3_pkg::OP_FINISH && !fin_r) begin
      buf_r[pos_r[5:2]][{~pos_r[1:0], 3'd0} +: 8] <= 8'h80;
    end else if (st_r == S_PAD) begin
      buf_r[pidx_r[5:2]][{~pidx_r[1:0], 3'd0} +: 8] <= pad_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      pos_r <= '0; bits_r <= '0; fin_r <= 1'b0;
      padding_r <= 1'b0; second_r <= 1'b0; pidx_r <= '0; pad_lenblk_r <= 1'b0;
      j_r <= '0; ld_r <= '0; k_r <= '0;
      for (int i = 0; i < 8; i++) v_r[i] <= sm3_pkg::iv_word(3'(i));
    end else begin
      unique case (st_r)
        S_IDLE: if (cmd_valid) begin
          unique case (cmd.opcode)
            sm3_pkg::OP_ABSORB: begin
              if (fin_r) begin
                st_r <= S_ERR;
              end else begin
                pos_r  <= pos_r + 6'd1;
                bits_r <= bits_r + 64'd8;
                if (pos_r == 6'd63) begin
                  padding_r <= 1'b0; ld_r <= '0; st_r <= S_LOAD;
                end
              end
            end
            sm3_pkg::OP_FINISH: begin
              k_r <= '0;
              if (fin_r) begin
                st_r <= S_EMIT;
              end else begin
                padding_r <= 1'b1;
                // fill after the marker; if the length no longer fits, one extra block
                pidx_r <= pos_r + 6'd1;
                second_r <= (pos_r >= 6'd56);
                pad_lenblk_r <= (pos_r < 6'd56);
                if (pos_r == 6'd63) begin
                  ld_r <= '0; st_r <= S_LOAD;
                end else begin
                  st_r <= S_PAD;
                end
              end
            end
            sm3_pkg::OP_RESTART: begin
              pos_r <= '0; bits_r <= '0; fin_r <= 1'b0;
              for (int i = 0; i < 8; i++) v_r[i] <= sm3_pkg::iv_word(3'(i));
            end
            default: ;
          endcase
        end
        S_PAD: begin
          pidx_r <= pidx_r + 6'd1;
          if (pidx_r == 6'd63) begin
            ld_r <= '0; st_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          w_r[ld_r] <= ld_word;
          ld_r <= ld_r + 4'd1;
          if (ld_r == 4'd15) begin
            a_r <= v_r[0]; b_r <= v_r[1]; c_r <= v_r[2]; d_r <= v_r[3];
            e_r <= v_r[4]; f_r <= v_r[5]; g_r <= v_r[6]; h_r <= v_r[7];
            j_r <= '0;
            st_r <= S_RND;
          end
        end
        S_RND: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= w16;
          d_r <= c_r; c_r <= sm3_pkg::rotl(b_r, 5'd9); b_r <= a_r; a_r <= tt1;
          h_r <= g_r; g_r <= sm3_pkg::rotl(f_r, 5'd19); f_r <= e_r;
          e_r <= sm3_pkg::perm0(tt2);
          j_r <= j_r + 6'd1;
          if (j_r == 6'd63) begin
            v_r[0] <= v_r[0] ^ tt1;  v_r[1] <= v_r[1] ^ a_r;
            v_r[2] <= v_r[2] ^ sm3_pkg::rotl(b_r, 5'd9); v_r[3] <= v_r[3] ^ c_r;
            v_r[4] <= v_r[4] ^ sm3_pkg::perm0(tt2); v_r[5] <= v_r[5] ^ e_r;
            v_r[6] <= v_r[6] ^ sm3_pkg::rotl(f_r, 5'd19); v_r[7] <= v_r[7] ^ g_r;
            if (!padding_r) begin
              st_r <= S_IDLE;
            end else if (second_r) begin
              second_r <= 1'b0; pad_lenblk_r <= 1'b1; pidx_r <= '0; st_r <= S_PAD;
            end else begin
              padding_r <= 1'b0; fin_r <= 1'b1;
              pos_r <= '0; bits_r <= '0; k_r <= '0;
              st_r <= S_EMIT;
            end
          end
        end
        S_EMIT: if (out_ready) begin
          k_r <= k_r + 3'd1;
          if (k_r == 3'd7) st_r <= S_IDLE;
        end
        S_ERR: if (out_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: hw/rtl/sm3_hash_engine_checker.sv
// ----------------------------------------------------------------------------
// SM3 port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module sm3_hash_engine_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last,
  input logic        out_status
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word))
    else $error("result dropped under stall");
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_last && out_word_index == 3'd0
      && out_digest_word == 32'd0)
    else $error("bad error transaction");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_status |-> out_last == (out_word_index == 3'd7))
    else $error("last mismatch");
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid
      && out_word_index == $past(out_word_index) + 3'd1)
    else $error("digest word order");
endmodule

bind sm3_hash_engine_top sm3_hash_engine_checker u_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_digest_word,
  .out_word_index, .out_last, .out_status
);
